// ===== hw/rtl/tcpu_pkg.sv =====
// ----------------------------------------------------------------------------
// tcpu_pkg: shared types and constants of the tiny processor core
// Field widths, opcode and action codes, the decoded command that travels
// from the front end through the queue to the back end.
// ----------------------------------------------------------------------------
package tcpu_pkg;

  localparam int unsigned WORD_W       = 16;
  localparam int unsigned ACTION_W     = 3;
  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned STATUS_W     = 2;
  localparam int unsigned REG_COUNT    = 16;
  localparam int unsigned REG_AW       = 4;
  localparam int unsigned IMM_W        = 4;
  localparam int unsigned TARGET_W     = 12;
  localparam int unsigned OPCODE_W     = 4;

  localparam int unsigned DATA_DEPTH_DEF = 65536;

  localparam int unsigned QUEUE_DEPTH  = 2;
  localparam int unsigned QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic [ACTION_W-1:0] ACT_EXEC       = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_WRITE_BYTE = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_SET_PC     = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_READ_REG   = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_READ_BYTE  = 3'd4;

  localparam logic [OPCODE_W-1:0] OPC_ADD    = 4'h0;
  localparam logic [OPCODE_W-1:0] OPC_LOAD   = 4'h2;
  localparam logic [OPCODE_W-1:0] OPC_STORE  = 4'h3;
  localparam logic [OPCODE_W-1:0] OPC_BRANCH = 4'h4;
  localparam logic [OPCODE_W-1:0] OPC_JUMP   = 4'hE;

  localparam logic [STATUS_W-1:0] ST_NORMAL = 2'd0;
  localparam logic [STATUS_W-1:0] ST_TAKEN  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD    = 2'd2;

  typedef enum logic [3:0] {
    K_ADD,
    K_LOAD,
    K_STORE,
    K_BRANCH,
    K_JUMP,
    K_BAD,
    K_WRITE_BYTE,
    K_SET_PC,
    K_READ_REG,
    K_READ_BYTE,
    K_NOP
  } kind_t;

  typedef struct packed {
    kind_t               kind;
    logic [REG_AW-1:0]   rd;
    logic [REG_AW-1:0]   ra;
    logic [REG_AW-1:0]   rb;
    logic [IMM_W-1:0]    imm;
    logic [TARGET_W-1:0] target;
    logic [WORD_W-1:0]   addr;
    logic [BYTE_W-1:0]   value;
  } cmd_t;

endpackage

// ===== hw/rtl/tcpu_if.sv =====
// ----------------------------------------------------------------------------
// tcpu_in_if / tcpu_out_if: valid/ready channels of the processor core
// One item moves at each clock edge where valid and ready are both high.
// ----------------------------------------------------------------------------
interface tcpu_in_if;
  logic                                valid;
  logic                                ready;
  logic [tcpu_pkg::ACTION_W-1:0]       action;
  logic [tcpu_pkg::WORD_W-1:0]         instr;
  logic [tcpu_pkg::WORD_W-1:0]         address;
  logic [tcpu_pkg::BYTE_W-1:0]         value;
  logic [tcpu_pkg::REG_AW-1:0]         reg_index;

  modport source (output valid, action, instr, address, value, reg_index, input ready);
  modport sink   (input valid, action, instr, address, value, reg_index, output ready);
endinterface

interface tcpu_out_if;
  logic                                valid;
  logic                                ready;
  logic [tcpu_pkg::WORD_W-1:0]         pc;
  logic [tcpu_pkg::STATUS_W-1:0]       status;
  logic [tcpu_pkg::WORD_W-1:0]         read_data;

  modport source (output valid, pc, status, read_data, input ready);
  modport sink   (input valid, pc, status, read_data, output ready);
endinterface

// ===== hw/rtl/tiny_cpu_execute_step.sv =====
// ----------------------------------------------------------------------------
// tiny_cpu_execute_step: tiny 16-bit processor core, one action per item
//
//   channel  | direction | payload
//   ---------+-----------+------------------------------------------------
//   in_ch    | in        | action, instr, address, value, reg_index
//   out_ch   | out       | pc, status, read_data
//
// One item per cycle while out_ch takes results; a result passes the queue,
// register read, execute and data memory, and write-back into the output
// register before it is valid on out_ch.
// Register reads and the data byte read go through registered RAM ports,
// and register writes reach later items by forwarding from write-back.
// Reset clears pc and the sixteen register valid bits at once; no sweep.
// A stalled output freezes the execution pipe; the two-entry command queue
// keeps taking transfers until it fills.
// ----------------------------------------------------------------------------
module tiny_cpu_execute_step #(
  parameter int unsigned DATA_DEPTH = tcpu_pkg::DATA_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  tcpu_in_if.sink     in_ch,
  tcpu_out_if.source  out_ch
);

  logic           push;
  logic           q_full;
  logic           pop;
  logic           head_valid;
  tcpu_pkg::cmd_t push_cmd;
  tcpu_pkg::cmd_t head_cmd;

  tcpu_front u_front (
    .in_ch  (in_ch),
    .q_full (q_full),
    .push   (push),
    .cmd    (push_cmd)
  );

  tcpu_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  tcpu_back #(.DATA_DEPTH(DATA_DEPTH)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule

// ===== hw/rtl/tcpu_ram.sv =====
// ----------------------------------------------------------------------------
// tcpu_ram: generic single-write, single-read RAM
// Registered read with enable; a read at the address being written returns
// the old contents.
// ----------------------------------------------------------------------------
module tcpu_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/tcpu_front.sv =====
// ----------------------------------------------------------------------------
// tcpu_front: input decode
// Classifies each incoming action and instruction word into a command and
// chooses the two register file read ports it will need.
// ----------------------------------------------------------------------------
module tcpu_front (
  tcpu_in_if.sink          in_ch,
  input  logic             q_full,
  output logic             push,
  output tcpu_pkg::cmd_t   cmd
);

  logic [tcpu_pkg::OPCODE_W-1:0] opcode;
  tcpu_pkg::kind_t               kind;

  assign opcode      = in_ch.instr[15:12];
  assign in_ch.ready = !q_full;
  assign push        = in_ch.valid && !q_full;

  always_comb begin
    unique case (in_ch.action)
      tcpu_pkg::ACT_EXEC: begin
        unique case (opcode)
          tcpu_pkg::OPC_ADD:    kind = tcpu_pkg::K_ADD;
          tcpu_pkg::OPC_LOAD:   kind = tcpu_pkg::K_LOAD;
          tcpu_pkg::OPC_STORE:  kind = tcpu_pkg::K_STORE;
          tcpu_pkg::OPC_BRANCH: kind = tcpu_pkg::K_BRANCH;
          tcpu_pkg::OPC_JUMP:   kind = tcpu_pkg::K_JUMP;
          default:              kind = tcpu_pkg::K_BAD;
        endcase
      end
      tcpu_pkg::ACT_WRITE_BYTE: kind = tcpu_pkg::K_WRITE_BYTE;
      tcpu_pkg::ACT_SET_PC:     kind = tcpu_pkg::K_SET_PC;
      tcpu_pkg::ACT_READ_REG:   kind = tcpu_pkg::K_READ_REG;
      tcpu_pkg::ACT_READ_BYTE:  kind = tcpu_pkg::K_READ_BYTE;
      default:                  kind = tcpu_pkg::K_NOP;
    endcase
  end

  always_comb begin
    cmd.kind   = kind;
    cmd.rd     = in_ch.instr[11:8];
    // Port A serves rs, or the register named by a read-back action.
    cmd.ra     = (kind == tcpu_pkg::K_READ_REG) ? in_ch.reg_index : in_ch.instr[7:4];
    // Port B serves rt for add, and rd for store data and the branch compare.
    cmd.rb     = (kind == tcpu_pkg::K_ADD) ? in_ch.instr[3:0] : in_ch.instr[11:8];
    cmd.imm    = in_ch.instr[3:0];
    cmd.target = in_ch.instr[11:0];
    cmd.addr   = in_ch.address;
    cmd.value  = in_ch.value;
  end

endmodule

// ===== hw/rtl/tcpu_queue.sv =====
// ----------------------------------------------------------------------------
// tcpu_queue: short command queue between front and back end
// A small FIFO of decoded commands so that either side can stall alone.
// ----------------------------------------------------------------------------
module tcpu_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  tcpu_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output tcpu_pkg::cmd_t head_cmd
);

  tcpu_pkg::cmd_t                   mem_r [tcpu_pkg::QUEUE_DEPTH];
  logic [tcpu_pkg::QPTR_W-1:0]      wr_ptr_r;
  logic [tcpu_pkg::QPTR_W-1:0]      rd_ptr_r;
  logic [tcpu_pkg::QCNT_W-1:0]      count_r;
  logic [tcpu_pkg::QCNT_W-1:0]      count_nxt;

  assign full       = (count_r == tcpu_pkg::QCNT_W'(tcpu_pkg::QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_cmd   = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= tcpu_pkg::QCNT_W'(tcpu_pkg::QUEUE_DEPTH))
    else $error("queue occupancy above its depth");
`endif

endmodule

// ===== hw/rtl/tcpu_back.sv =====
// ----------------------------------------------------------------------------
// tcpu_back: execution pipeline
// Three stages: register read, execute and data memory access, write-back
// into the output register. The whole pipe moves when the output register
// can take a result; register values are forwarded from write-back.
// ----------------------------------------------------------------------------
module tcpu_back #(
  parameter int unsigned DATA_DEPTH = tcpu_pkg::DATA_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             head_valid,
  input  tcpu_pkg::cmd_t   head_cmd,
  output logic             pop,
  tcpu_out_if.source       out_ch
);

  localparam int unsigned AddrW    = $clog2(DATA_DEPTH);
  localparam bit          DepthPow2 = ((DATA_DEPTH & (DATA_DEPTH - 1)) == 0);
  localparam logic [23:0] DepthW    = 24'(DATA_DEPTH);

  localparam int unsigned WW = tcpu_pkg::WORD_W;
  localparam int unsigned RW = tcpu_pkg::REG_AW;
  localparam int unsigned BW = tcpu_pkg::BYTE_W;

  // Reduces a 16-bit byte address into the store. The depth must be at least 256,
  // which the block does not enforce; the quotient then stays below 256, so eight restoring steps suffice.
  function automatic logic [AddrW-1:0] slot_of(input logic [WW-1:0] a);
    logic [23:0] rem;
    rem = {8'b0, a};
    for (int k = 7; k >= 0; k--) begin
      if (rem >= (DepthW << k)) begin
        rem = rem - (DepthW << k);
      end
    end
    return rem[AddrW-1:0];
  endfunction

  logic adv;

  // Register file valid bits and last completed write.
  logic [tcpu_pkg::REG_COUNT-1:0] rf_valid_r;
  logic                           lw_valid_r;
  logic [RW-1:0]                  lw_idx_r;
  logic [WW-1:0]                  lw_data_r;

  // Execute stage.
  logic           s2_valid_r;
  tcpu_pkg::cmd_t s2_cmd_r;
  logic           ra_ok_r;
  logic           rb_ok_r;
  logic [WW-1:0]  rfa_rdata;
  logic [WW-1:0]  rfb_rdata;

  // Write-back stage.
  logic                          s3_valid_r;
  tcpu_pkg::kind_t               s3_kind_r;
  logic [RW-1:0]                 s3_rd_r;
  logic [WW-1:0]                 s3_pc_r;
  logic [tcpu_pkg::STATUS_W-1:0] s3_status_r;
  logic [WW-1:0]                 s3_res_r;

  // Output register.
  logic                          out_valid_r;
  logic [WW-1:0]                 out_pc_r;
  logic [tcpu_pkg::STATUS_W-1:0] out_status_r;
  logic [WW-1:0]                 out_rdata_r;

  logic [WW-1:0] pc_r;
  logic [WW-1:0] pc_nxt;

  logic [WW-1:0]                 opa;
  logic [WW-1:0]                 opb;
  logic [WW-1:0]                 imm_ext;
  logic [WW-1:0]                 ea;
  logic [WW-1:0]                 mem_addr16;
  logic [AddrW-1:0]              slot;
  logic [WW-1:0]                 s2_res;
  logic [tcpu_pkg::STATUS_W-1:0] s2_status;
  logic                          dm_we;
  logic [BW-1:0]                 dm_wdata;
  logic [BW-1:0]                 dm_rdata;

  logic          s3_wr_en;
  logic [WW-1:0] s3_wdata;
  logic          rf_we;
  logic [WW-1:0] s3_read_data;

  assign adv = !out_valid_r || out_ch.ready;
  assign pop = adv && head_valid;

  // ---------------- register read ----------------
  tcpu_ram #(.WIDTH(WW), .DEPTH(tcpu_pkg::REG_COUNT)) u_rf_a (
    .clk   (clk),
    .we    (rf_we),
    .waddr (s3_rd_r),
    .wdata (s3_wdata),
    .re    (adv),
    .raddr (head_cmd.ra),
    .rdata (rfa_rdata)
  );

  tcpu_ram #(.WIDTH(WW), .DEPTH(tcpu_pkg::REG_COUNT)) u_rf_b (
    .clk   (clk),
    .we    (rf_we),
    .waddr (s3_rd_r),
    .wdata (s3_wdata),
    .re    (adv),
    .raddr (head_cmd.rb),
    .rdata (rfb_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s2_valid_r <= head_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_cmd_r <= head_cmd;
      ra_ok_r  <= rf_valid_r[head_cmd.ra];
      rb_ok_r  <= rf_valid_r[head_cmd.rb];
    end
  end

  // ---------------- execute ----------------
  assign s3_wr_en = s3_valid_r &&
                    ((s3_kind_r == tcpu_pkg::K_ADD) || (s3_kind_r == tcpu_pkg::K_LOAD));
  assign s3_wdata = (s3_kind_r == tcpu_pkg::K_LOAD) ? {{(WW-BW){1'b0}}, dm_rdata} : s3_res_r;

  // The write-back stage has not written yet, and the last completed write
  // landed in the same edge the read was taken, so both are forwarded.
  always_comb begin
    if (s3_wr_en && (s3_rd_r == s2_cmd_r.ra)) begin
      opa = s3_wdata;
    end else if (lw_valid_r && (lw_idx_r == s2_cmd_r.ra)) begin
      opa = lw_data_r;
    end else begin
      opa = ra_ok_r ? rfa_rdata : '0;
    end
    if (s3_wr_en && (s3_rd_r == s2_cmd_r.rb)) begin
      opb = s3_wdata;
    end else if (lw_valid_r && (lw_idx_r == s2_cmd_r.rb)) begin
      opb = lw_data_r;
    end else begin
      opb = rb_ok_r ? rfb_rdata : '0;
    end
  end

  assign imm_ext    = {{(WW-tcpu_pkg::IMM_W){s2_cmd_r.imm[tcpu_pkg::IMM_W-1]}}, s2_cmd_r.imm};
  assign ea         = opa + imm_ext;
  assign mem_addr16 = ((s2_cmd_r.kind == tcpu_pkg::K_LOAD) ||
                       (s2_cmd_r.kind == tcpu_pkg::K_STORE)) ? ea : s2_cmd_r.addr;
  assign slot       = DepthPow2 ? mem_addr16[AddrW-1:0] : slot_of(mem_addr16);

  always_comb begin
    pc_nxt    = pc_r;
    s2_status = tcpu_pkg::ST_NORMAL;
    s2_res    = '0;
    unique case (s2_cmd_r.kind)
      tcpu_pkg::K_ADD: begin
        s2_res = opa + opb;
        pc_nxt = pc_r + 1'b1;
      end
      tcpu_pkg::K_LOAD, tcpu_pkg::K_STORE: begin
        pc_nxt = pc_r + 1'b1;
      end
      tcpu_pkg::K_BRANCH: begin
        if (opa == opb) begin
          pc_nxt    = pc_r + imm_ext;
          s2_status = tcpu_pkg::ST_TAKEN;
        end else begin
          pc_nxt = pc_r + 1'b1;
        end
      end
      tcpu_pkg::K_JUMP: begin
        pc_nxt    = {{(WW-tcpu_pkg::TARGET_W){1'b0}}, s2_cmd_r.target};
        s2_status = tcpu_pkg::ST_TAKEN;
      end
      tcpu_pkg::K_BAD: begin
        s2_status = tcpu_pkg::ST_BAD;
      end
      tcpu_pkg::K_SET_PC: begin
        pc_nxt = s2_cmd_r.addr;
      end
      tcpu_pkg::K_READ_REG: begin
        s2_res = opa;
      end
      tcpu_pkg::K_WRITE_BYTE, tcpu_pkg::K_READ_BYTE, tcpu_pkg::K_NOP: begin
        pc_nxt = pc_r;
      end
      default: begin
        pc_nxt = pc_r;
      end
    endcase
  end

  assign dm_we    = adv && s2_valid_r &&
                    ((s2_cmd_r.kind == tcpu_pkg::K_STORE) ||
                     (s2_cmd_r.kind == tcpu_pkg::K_WRITE_BYTE));
  assign dm_wdata = (s2_cmd_r.kind == tcpu_pkg::K_STORE) ? opb[BW-1:0] : s2_cmd_r.value;

  tcpu_ram #(.WIDTH(BW), .DEPTH(DATA_DEPTH)) u_dmem (
    .clk   (clk),
    .we    (dm_we),
    .waddr (slot),
    .wdata (dm_wdata),
    .re    (adv),
    .raddr (slot),
    .rdata (dm_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r       <= '0;
      s3_valid_r <= 1'b0;
    end else if (adv) begin
      s3_valid_r <= s2_valid_r;
      if (s2_valid_r) begin
        pc_r <= pc_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_kind_r   <= s2_cmd_r.kind;
      s3_rd_r     <= s2_cmd_r.rd;
      s3_pc_r     <= pc_nxt;
      s3_status_r <= s2_status;
      s3_res_r    <= s2_res;
    end
  end

  // ---------------- write-back and output ----------------
  assign rf_we = adv && s3_wr_en;

  always_comb begin
    unique case (s3_kind_r)
      tcpu_pkg::K_READ_REG:  s3_read_data = s3_res_r;
      tcpu_pkg::K_READ_BYTE: s3_read_data = {{(WW-BW){1'b0}}, dm_rdata};
      default:               s3_read_data = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rf_valid_r  <= '0;
      lw_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s3_valid_r;
      lw_valid_r  <= rf_we;
      if (rf_we) begin
        rf_valid_r[s3_rd_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lw_idx_r     <= s3_rd_r;
      lw_data_r    <= s3_wdata;
      out_pc_r     <= s3_pc_r;
      out_status_r <= s3_status_r;
      out_rdata_r  <= s3_read_data;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.pc        = out_pc_r;
  assign out_ch.status    = out_status_r;
  assign out_ch.read_data = out_rdata_r;

`ifndef SYNTHESIS
  a_pc_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(pc_r))
    else $error("program counter moved while the pipeline was stalled");

  a_taken_kind: assert property (@(posedge clk) disable iff (!rst_n)
    s3_valid_r && (s3_status_r == tcpu_pkg::ST_TAKEN) |->
      (s3_kind_r == tcpu_pkg::K_BRANCH) || (s3_kind_r == tcpu_pkg::K_JUMP))
    else $error("taken status on an item that is neither branch nor jump");

  a_fwd_written: assert property (@(posedge clk) disable iff (!rst_n)
    lw_valid_r |-> rf_valid_r[lw_idx_r])
    else $error("forwarded register write not marked in the valid bits");
`endif

endmodule
